// ===== hdl/aocs_pkg.sv =====
`timescale 1ns / 1ps

package aocs_pkg;

	// Fixed field geometry
	localparam int CHANNELS   = 4;
	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 16;
	localparam int CURRENT_W  = 29;
	localparam int IN_DATA_W  = 48;   // 4 x 12 bits, already byte aligned
	localparam int OUT_DATA_W = 120;  // 4 x 29 bits, padded to 15 bytes
	localparam int OUT_PAD_W  = OUT_DATA_W - CHANNELS * CURRENT_W;

	// Default calibration lengths
	localparam int CAL_SAMPLES_DEF    = 256;
	localparam int SETTLE_SAMPLES_DEF = 10;

	// Register map
	localparam int ADDR_W   = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_CURRENT_GAIN = 1'b0;  // word index, paddr[2]
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);

	typedef logic [SAMPLE_W-1:0]         sample_t;
	typedef logic [GAIN_W-1:0]           gain_t;
	typedef logic signed [CURRENT_W-1:0] current_t;

	// Per-beat strobes from the controller to every lane
	typedef struct packed {
		logic s1_en;     // beat accepted into stage 1
		logic acc_en;    // add this beat into the offset sums
		logic s2_en;     // stage 1 moves into the output register
		logic load_s1;   // stage 1 holds the last calibration beat
	} lane_ctl_t;

endpackage

// ===== hdl/adc_offset_calibrate_and_scale_core.sv =====
`timescale 1ns / 1ps

// ADC zero-offset calibration and gain scaling. Each input beat carries one
// sample set of four 12-bit channels; each output beat carries, per channel,
// (offset - sample) * current_gain as a 29-bit signed current, plus the
// calibrated flag. After reset the first CAL_SAMPLES sets are summed per
// channel and each offset becomes floor(sum / CAL_SAMPLES), applied from the
// following set on; calibrated rises SETTLE_SAMPLES sets later and stays
// high until reset. The block takes one set per clock cycle unless m_tready
// holds the output back; each beat passes through a sample register, then the
// per-lane subtract and 13x17 gain multiply into the output register. The
// offset divide is a reciprocal multiply done as the last calibration set
// leaves the first stage. No clearing pass is needed after reset. Write
// current_gain only while the block is idle.
module adc_offset_calibrate_and_scale_core #(
	parameter int CAL_SAMPLES    = aocs_pkg::CAL_SAMPLES_DEF,
	parameter int SETTLE_SAMPLES = aocs_pkg::SETTLE_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [aocs_pkg::IN_DATA_W-1:0]    s_tdata,   // sample_a, sample_b, sample_c, sample_d
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [aocs_pkg::OUT_DATA_W-1:0]   m_tdata,   // current_a, current_b, current_c, current_d, zero pad
	output logic                              m_tuser,   // calibrated
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aocs_pkg::ADDR_W-1:0]       paddr,
	input  logic [aocs_pkg::PDATA_W-1:0]      pwdata,
	output logic [aocs_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import aocs_pkg::*;

	gain_t     gain_q;
	lane_ctl_t ctl;
	sample_t   sample [CHANNELS];
	current_t  current [CHANNELS];

	// Register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CURRENT_GAIN)) begin
			gain_q <= pwdata[GAIN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CURRENT_GAIN) ? PDATA_W'(gain_q) : '0;

	aocs_ctrl #(
		.CAL_SAMPLES    (CAL_SAMPLES),
		.SETTLE_SAMPLES (SETTLE_SAMPLES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.ctl        (ctl),
		.calibrated (m_tuser)
	);

	// One lane per channel
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		assign sample[ch] = s_tdata[ch*SAMPLE_W +: SAMPLE_W];

		aocs_lane #(
			.CAL_SAMPLES (CAL_SAMPLES)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sample  (sample[ch]),
			.gain    (gain_q),
			.current (current[ch])
		);
	end

	// Merge lane results into the output beat
	always_comb begin
		m_tdata = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			m_tdata[ch*CURRENT_W +: CURRENT_W] = current[ch];
		end
	end

endmodule

// ===== hdl/aocs_lane.sv =====
`timescale 1ns / 1ps

module aocs_lane #(
	parameter int CAL_SAMPLES = aocs_pkg::CAL_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aocs_pkg::lane_ctl_t  ctl,
	input  aocs_pkg::sample_t    sample,
	input  aocs_pkg::gain_t      gain,
	output aocs_pkg::current_t   current
);
	import aocs_pkg::*;

	// Accumulator width and reciprocal for an exact floor(sum / CAL_SAMPLES)
	localparam int DIV_L  = $clog2(CAL_SAMPLES);
	localparam int SUM_W  = SAMPLE_W + DIV_L;
	localparam int RCP_W  = SUM_W + 1;
	localparam int DIV_K  = SUM_W + DIV_L;
	localparam longint unsigned RCP_FULL =
		((64'd1 << DIV_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);
	localparam int QP_W = SUM_W + RCP_W;

	logic [SUM_W-1:0]                 sum_q;
	sample_t                          offset_q;
	sample_t                          sample_s1;
	current_t                         current_s2;
	logic [QP_W-1:0]                  quot_prod;
	logic signed [SAMPLE_W:0]         diff;
	logic signed [SAMPLE_W+GAIN_W+1:0] prod;

	// Offset sum and offset; the offset switches when the last
	// calibration beat leaves stage 1, so that beat still sees the old one
	assign quot_prod = QP_W'(sum_q) * QP_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			offset_q <= '0;
		end else begin
			if (ctl.acc_en) begin
				sum_q <= sum_q + SUM_W'(sample);
			end
			if (ctl.s2_en && ctl.load_s1) begin
				offset_q <= quot_prod[DIV_K +: SAMPLE_W];
			end
		end
	end

	// Stage 1: sample register
	always_ff @(posedge clk) begin
		if (ctl.s1_en) begin
			sample_s1 <= sample;
		end
	end

	// Stage 2: (offset - sample) * gain
	assign diff = $signed({1'b0, offset_q}) - $signed({1'b0, sample_s1});
	assign prod = diff * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (ctl.s2_en) begin
			current_s2 <= prod[CURRENT_W-1:0];
		end
	end

	assign current = current_s2;

endmodule

// ===== hdl/aocs_ctrl.sv =====
`timescale 1ns / 1ps

module aocs_ctrl #(
	parameter int CAL_SAMPLES    = aocs_pkg::CAL_SAMPLES_DEF,
	parameter int SETTLE_SAMPLES = aocs_pkg::SETTLE_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output aocs_pkg::lane_ctl_t ctl,
	output logic                calibrated
);
	import aocs_pkg::*;

	localparam int CNT_W = $clog2(CAL_SAMPLES + SETTLE_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CAL_CNT  = CNT_W'(CAL_SAMPLES);
	localparam logic [CNT_W-1:0] LAST_CAL = CNT_W'(CAL_SAMPLES - 1);
	localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(CAL_SAMPLES + SETTLE_SAMPLES);

	logic             v1_q;
	logic             v2_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic             done_q;
	logic             load_s1;
	logic             cal_s1;
	logic             cal_s2;
	logic             accept;
	logic             adv;
	logic             acc_en;
	logic             done_nxt;

	// Two-stage handshake: output register frees, stage 1 moves on
	assign adv      = v1_q && (!v2_q || m_tready);
	assign s_tready = !v1_q || !v2_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Calibration bookkeeping for the accepted beat
	assign cnt_inc  = cnt_q + 1'b1;
	assign acc_en   = accept && !done_q && (cnt_q < CAL_CNT);
	assign done_nxt = done_q || (cnt_inc >= DONE_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			load_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv) begin
				v1_q <= 1'b0;
			end
			if (adv) begin
				v2_q <= 1'b1;
			end else if (m_tready) begin
				v2_q <= 1'b0;
			end
			if (accept) begin
				load_s1 <= acc_en && (cnt_q == LAST_CAL);
				if (!done_q) begin
					cnt_q  <= cnt_inc;
					done_q <= done_nxt;
				end
			end
		end
	end

	// Calibrated flag rides along with its beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cal_s1 <= done_nxt;
		end
		if (adv) begin
			cal_s2 <= cal_s1;
		end
	end

	assign ctl.s1_en   = accept;
	assign ctl.acc_en  = acc_en;
	assign ctl.s2_en   = adv;
	assign ctl.load_s1 = load_s1;

	assign m_tvalid   = v2_q;
	assign calibrated = cal_s2;

endmodule
